FILE: hw/rtl/dfe_pkg.sv
package dfe_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int WORK_DEPTH  = 5;
   localparam int COUNT_W     = $clog2(WORK_DEPTH + 1);

   localparam logic [7:0] ASCII_UPPER_I   = 8'h49;
   localparam logic [7:0] ASCII_LOWER_I   = 8'h69;
   localparam logic [7:0] ASCII_LOWER_L   = 8'h6C;
   localparam logic [7:0] ASCII_UPPER_L   = 8'h4C;
   localparam logic [7:0] ASCII_LOWER_S   = 8'h73;
   localparam logic [7:0] TAG_DISTINCT    = 8'h38;
   localparam logic [7:0] NO_TAG          = 8'h00;
   localparam logic [7:0] LEAD_C2         = 8'hC2;
   localparam logic [7:0] LEAD_C3         = 8'hC3;
   localparam logic [7:0] LEAD_C4         = 8'hC4;
   localparam logic [7:0] LEAD_C5         = 8'hC5;
   localparam logic [7:0] LEAD_C7         = 8'hC7;
   localparam logic [7:0] LEAD_C8         = 8'hC8;
   localparam logic [7:0] LEAD_E1         = 8'hE1;
   localparam logic [7:0] TRAIL_B7        = 8'hB7;
   localparam logic [7:0] TRAIL_BA        = 8'hBA;
   localparam logic [7:0] TRAIL_9E        = 8'h9E;
   localparam logic [7:0] TRAIL_B0        = 8'hB0;
   localparam logic [7:0] TRAIL_B1        = 8'hB1;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_TURK_I,
      KIND_TURK_B0
   } kind_type;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
      kind_type   kind;
   } entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_TAG
   } back_state_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] base;
      logic [7:0] tag;
   } fold_type;

   function automatic fold_type mk_fold(input logic [7:0] base, input logic [7:0] tag);
      fold_type res;
      res.hit  = 1'b1;
      res.base = base;
      res.tag  = tag;
      return res;
   endfunction

   function automatic fold_type fold_plain(input logic [7:0] c);
      fold_type res;
      res.hit  = 1'b0;
      res.base = c;
      res.tag  = NO_TAG;
      if (c >= 8'h41 && c <= 8'h5A) begin
         res.hit  = 1'b1;
         res.base = c + 8'd32;
      end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                   c == 8'h20 || c == 8'h23 || c == 8'h2F) begin
         res.hit = 1'b1;
      end
      return res;
   endfunction

   function automatic logic is_lead(input logic [7:0] c);
      return c == LEAD_C3 || c == LEAD_C4 || c == LEAD_C5 || c == LEAD_C7 ||
             c == LEAD_C8 || c == LEAD_E1 || c == ASCII_LOWER_L || c == ASCII_UPPER_L;
   endfunction

   function automatic fold_type fold_pair(input logic [7:0] lead, input logic [7:0] trail);
      fold_type res;
      res = '{hit: 1'b0, base: 8'h00, tag: NO_TAG};
      unique case ({lead, trail}) inside
         16'hC481, 16'hC480:                     res = mk_fold("a", "1");
         16'hC493, 16'hC492:                     res = mk_fold("e", "1");
         16'hC4AB, 16'hC4AA:                     res = mk_fold("i", "1");
         16'hC58D, 16'hC58C:                     res = mk_fold("o", "1");
         16'hC5AB, 16'hC5AA:                     res = mk_fold("u", "1");
         16'hC3A1, 16'hC381:                     res = mk_fold("a", "2");
         16'hC3A9, 16'hC389:                     res = mk_fold("e", "2");
         16'hC3AD, 16'hC38D:                     res = mk_fold("i", "2");
         16'hC3B3, 16'hC393:                     res = mk_fold("o", "2");
         16'hC3BA, 16'hC39A:                     res = mk_fold("u", "2");
         16'hC3BD, 16'hC39D:                     res = mk_fold("y", "2");
         16'hC78E, 16'hC78D, 16'hC483, 16'hC482: res = mk_fold("a", "3");
         16'hC49B, 16'hC49A:                     res = mk_fold("e", "3");
         16'hC790, 16'hC78F:                     res = mk_fold("i", "3");
         16'hC792, 16'hC791:                     res = mk_fold("o", "3");
         16'hC794, 16'hC793:                     res = mk_fold("u", "3");
         16'hC5A1, 16'hC5A0:                     res = mk_fold("s", "3");
         16'hC48D, 16'hC48C:                     res = mk_fold("c", "3");
         16'hC5BE, 16'hC5BD:                     res = mk_fold("z", "3");
         16'hC599, 16'hC598:                     res = mk_fold("r", "3");
         16'hC588, 16'hC587:                     res = mk_fold("n", "3");
         16'hC4BE, 16'hC4BD:                     res = mk_fold("l", "3");
         16'hC5A5, 16'hC5A4:                     res = mk_fold("t", "3");
         16'hC48F, 16'hC48E:                     res = mk_fold("d", "3");
         16'hC49F, 16'hC49E:                     res = mk_fold("g", "3");
         16'hC3A0, 16'hC380:                     res = mk_fold("a", "4");
         16'hC3A8, 16'hC388:                     res = mk_fold("e", "4");
         16'hC3AC, 16'hC38C:                     res = mk_fold("i", "4");
         16'hC3B2, 16'hC392:                     res = mk_fold("o", "4");
         16'hC3B9, 16'hC399:                     res = mk_fold("u", "4");
         16'hC3A2, 16'hC382:                     res = mk_fold("a", "5");
         16'hC3AA, 16'hC38A:                     res = mk_fold("e", "5");
         16'hC3AE, 16'hC38E:                     res = mk_fold("i", "5");
         16'hC3B4, 16'hC394:                     res = mk_fold("o", "5");
         16'hC3BB, 16'hC39B:                     res = mk_fold("u", "5");
         16'hC3A4, 16'hC384:                     res = mk_fold("a", "6");
         16'hC3AB, 16'hC38B:                     res = mk_fold("e", "6");
         16'hC3AF, 16'hC38F:                     res = mk_fold("i", "6");
         16'hC3B6, 16'hC396:                     res = mk_fold("o", "6");
         16'hC3BC, 16'hC39C:                     res = mk_fold("u", "6");
         16'hC3BF, 16'hC5B8:                     res = mk_fold("y", "6");
         16'hC3A3, 16'hC383:                     res = mk_fold("a", "7");
         16'hC3B1, 16'hC391:                     res = mk_fold("n", "7");
         16'hC3B5, 16'hC395:                     res = mk_fold("o", "7");
         16'hC39F:                               res = mk_fold("s", "8");
         16'hC4B1:                               res = mk_fold("i", "8");
         16'hC3A7, 16'hC387:                     res = mk_fold("c", NO_TAG);
         16'hC5AF, 16'hC5AE:                     res = mk_fold("u", NO_TAG);
         16'hC899, 16'hC898, 16'hC59F, 16'hC59E: res = mk_fold("s", NO_TAG);
         16'hC89B, 16'hC89A:                     res = mk_fold("t", NO_TAG);
         default:                                res = '{hit: 1'b0, base: 8'h00, tag: NO_TAG};
      endcase
      return res;
   endfunction

endpackage

FILE: hw/rtl/dfe_front.sv
module dfe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output dfe_pkg::entry_type   push_entry
);

   logic               turkish_ff;
   logic               turkish_in;
   dfe_pkg::kind_type  kind;

   assign csr_ready  = 1'b1;
   assign turkish_in = (csr_valid && csr_ready) ? csr_data : turkish_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turkish_ff <= 1'b0;
      end else begin
         turkish_ff <= turkish_in;
      end
   end

   always_comb begin
      kind = dfe_pkg::KIND_PLAIN;
      if (turkish_ff && req_tdata == dfe_pkg::ASCII_UPPER_I) begin
         kind = dfe_pkg::KIND_TURK_I;
      end else if (turkish_ff && req_tdata == dfe_pkg::TRAIL_B0) begin
         kind = dfe_pkg::KIND_TURK_B0;
      end
   end

   assign push_valid      = req_tvalid;
   assign req_tready      = push_ready;
   assign push_entry.text = req_tdata;
   assign push_entry.eot  = req_tlast;
   assign push_entry.kind = kind;

endmodule

FILE: hw/rtl/dfe_queue.sv
module dfe_queue #(
   parameter int DEPTH = dfe_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dfe_pkg::entry_type   in_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dfe_pkg::entry_type   out_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfe_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic               push;
   logic               pop;

   assign in_ready  = fill_ff != CNT_W'(DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_entry = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

FILE: hw/rtl/dfe_back.sv
module dfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  dfe_pkg::entry_type   pop_entry,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int WD = dfe_pkg::WORK_DEPTH;
   localparam int CW = dfe_pkg::COUNT_W;

   dfe_pkg::back_state_type state_ff;
   dfe_pkg::back_state_type state_in;

   logic [WD-1:0][7:0] work_ff;
   logic [WD-1:0][7:0] work_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               eot_ff;
   logic               eot_in;
   logic [7:0]         tag_ff;
   logic [7:0]         tag_in;
   logic [7:0]         hold_ff;
   logic [7:0]         hold_in;
   logic               hold_valid_ff;
   logic               hold_valid_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_data_ff;
   logic [7:0]         rsp_data_in;
   logic               rsp_has_ff;
   logic               rsp_has_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   logic [7:0]         w0;
   logic [7:0]         w1;
   logic [7:0]         w2;
   logic [7:0]         w3;
   logic               l_start;
   logic               match4;
   logic               match3;
   logic               match2;
   logic               match_any;
   logic               prefix;
   logic               scan_done;
   dfe_pkg::fold_type  pair;
   dfe_pkg::fold_type  plain;

   logic               step_emit;
   logic [7:0]         step_byte;
   logic [7:0]         step_tag;
   logic               go_tag;
   logic [2:0]         consume;
   logic               finish;
   logic               need_push;
   logic               out_free;
   logic               stall;
   logic               pop;

   assign w0 = work_ff[0];
   assign w1 = work_ff[1];
   assign w2 = work_ff[2];
   assign w3 = work_ff[3];

   assign l_start = (w0 == dfe_pkg::ASCII_LOWER_L || w0 == dfe_pkg::ASCII_UPPER_L) &&
                    w1 == dfe_pkg::LEAD_C2;
   assign match4  = count_ff >= CW'(4) && l_start && w2 == dfe_pkg::TRAIL_B7 &&
                    (w3 == dfe_pkg::ASCII_LOWER_L || w3 == dfe_pkg::ASCII_UPPER_L);
   assign match3  = count_ff >= CW'(3) && w0 == dfe_pkg::LEAD_E1 &&
                    w1 == dfe_pkg::TRAIL_BA && w2 == dfe_pkg::TRAIL_9E;
   assign pair    = dfe_pkg::fold_pair(w0, w1);
   assign plain   = dfe_pkg::fold_plain(w0);
   assign match2  = count_ff >= CW'(2) && pair.hit;
   assign match_any = match4 || match3 || match2;

   always_comb begin
      prefix = 1'b0;
      if (count_ff == CW'(1)) begin
         prefix = dfe_pkg::is_lead(w0);
      end else if (count_ff == CW'(2)) begin
         prefix = l_start || (w0 == dfe_pkg::LEAD_E1 && w1 == dfe_pkg::TRAIL_BA);
      end else if (count_ff == CW'(3)) begin
         prefix = l_start && w2 == dfe_pkg::TRAIL_B7;
      end
   end

   assign scan_done = count_ff == '0 || (!match_any && prefix && !eot_ff);

   always_comb begin
      step_emit = 1'b0;
      step_byte = 8'h00;
      step_tag  = dfe_pkg::NO_TAG;
      go_tag    = 1'b0;
      consume   = 3'd0;
      if (state_ff == dfe_pkg::ST_TAG) begin
         step_emit = 1'b1;
         step_byte = tag_ff;
      end else if (state_ff == dfe_pkg::ST_SCAN && !scan_done) begin
         if (match4) begin
            step_emit = 1'b1;
            step_byte = dfe_pkg::ASCII_LOWER_L;
            step_tag  = dfe_pkg::TAG_DISTINCT;
            go_tag    = 1'b1;
            consume   = 3'd4;
         end else if (match3) begin
            step_emit = 1'b1;
            step_byte = dfe_pkg::ASCII_LOWER_S;
            step_tag  = dfe_pkg::TAG_DISTINCT;
            go_tag    = 1'b1;
            consume   = 3'd3;
         end else if (match2) begin
            step_emit = 1'b1;
            step_byte = pair.base;
            step_tag  = pair.tag;
            go_tag    = pair.tag != dfe_pkg::NO_TAG;
            consume   = 3'd2;
         end else begin
            step_emit = plain.hit;
            step_byte = plain.base;
            consume   = 3'd1;
         end
      end
   end

   assign finish    = state_ff == dfe_pkg::ST_SCAN && scan_done;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign need_push = (step_emit && hold_valid_ff) || (finish && (hold_valid_ff || eot_ff));
   assign stall     = need_push && !out_free;
   assign pop       = !stall && pop_valid && (state_ff == dfe_pkg::ST_LOAD || finish);
   assign pop_ready = pop;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfe_pkg::ST_LOAD: begin
            if (pop) begin
               state_in = dfe_pkg::ST_SCAN;
            end
         end
         dfe_pkg::ST_SCAN: begin
            if (!stall) begin
               if (finish) begin
                  state_in = pop ? dfe_pkg::ST_SCAN : dfe_pkg::ST_LOAD;
               end else if (go_tag) begin
                  state_in = dfe_pkg::ST_TAG;
               end
            end
         end
         dfe_pkg::ST_TAG: begin
            if (!stall) begin
               state_in = dfe_pkg::ST_SCAN;
            end
         end
         default: state_in = dfe_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      work_in       = work_ff;
      count_in      = count_ff;
      eot_in        = eot_ff;
      tag_in        = tag_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      if (!stall) begin
         if (step_emit) begin
            if (hold_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               rsp_has_in   = 1'b1;
               rsp_last_in  = 1'b0;
            end
            hold_in       = step_byte;
            hold_valid_in = 1'b1;
         end
         if (go_tag) begin
            tag_in = step_tag;
         end
         if (finish) begin
            if (hold_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = hold_ff;
               rsp_has_in    = 1'b1;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
            end else if (eot_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'h00;
               rsp_has_in   = 1'b0;
               rsp_last_in  = 1'b1;
            end
         end
         if (consume != 3'd0) begin
            work_in  = work_ff >> {consume, 3'b000};
            count_in = count_ff - CW'(consume);
         end
         if (pop) begin
            eot_in = pop_entry.eot;
            case (pop_entry.kind)
               dfe_pkg::KIND_TURK_I: begin
                  for (int i = 0; i < WD; i++) begin
                     if (CW'(i) == count_ff) begin
                        work_in[i] = dfe_pkg::LEAD_C4;
                     end
                     if (CW'(i) == count_ff + CW'(1)) begin
                        work_in[i] = dfe_pkg::TRAIL_B1;
                     end
                  end
                  count_in = count_ff + CW'(2);
               end
               dfe_pkg::KIND_TURK_B0: begin
                  if (count_ff == CW'(1) && w0 == dfe_pkg::LEAD_C4) begin
                     work_in[0] = dfe_pkg::ASCII_LOWER_I;
                  end else begin
                     for (int i = 0; i < WD; i++) begin
                        if (CW'(i) == count_ff) begin
                           work_in[i] = dfe_pkg::TRAIL_B0;
                        end
                     end
                     count_in = count_ff + CW'(1);
                  end
               end
               default: begin
                  for (int i = 0; i < WD; i++) begin
                     if (CW'(i) == count_ff) begin
                        work_in[i] = pop_entry.text;
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dfe_pkg::ST_LOAD;
         count_ff      <= '0;
         eot_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         eot_ff        <= eot_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      tag_ff      <= tag_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/diacritic_fold_encoder_core.sv
// A beat is registered in the input queue, then popped into the scan unit's work buffer.
// Each result byte waits in a hold register until the next byte or the beat's end moves it out.
// Bytes are folded or dropped one at a time; closing a beat pops the next queued beat with it.
// The single result register and the queue depth set how far each side can stall alone.
// Synchronous reset empties the queue and the pending bytes and clears Turkish mode.
module diacritic_fold_encoder_core #(
   parameter int QUEUE_DEPTH = dfe_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // text_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tuser,   // has_byte
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic               push_valid;
   logic               push_ready;
   dfe_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_ready;
   dfe_pkg::entry_type pop_entry;

   dfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   dfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: dv/diacritic_fold_encoder_core_tb.sv
module diacritic_fold_encoder_core_tb;

   localparam int STALL_LIMIT    = 2000;
   localparam int SQUEEZE_AFTER  = 150;
   localparam int SQUEEZE_CYCLES = 160;
   localparam int PHASE_BYTES    = 70;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_in_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
   } fold_out_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // text_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // out_byte
   logic       rsp_tuser;            // has_byte
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_data   = 1'b0;

   text_in_type  text_q [$];
   fold_out_type fold_q [$];
   text_in_type  next_in;

   logic [7:0] held [3];
   int         held_n  = 0;
   logic       turk_on = 1'b0;
   logic [7:0] scan_buf [6];

   int pushed      = 0;
   int useful      = 0;
   int beats_in    = 0;
   int rsp_seen    = 0;
   int marker_seen = 0;
   int errors      = 0;
   int idle_cycles = 0;
   int send_gap    = 0;
   int recv_hold   = 0;
   bit send_calm   = 1'b0;
   bit recv_calm   = 1'b0;
   bit squeezed    = 1'b0;

   diacritic_fold_encoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit pair_fold(input logic [7:0] lead, input logic [7:0] trail,
                                    output logic [7:0] base, output logic [7:0] tag);
      logic [7:0] t;
      {base, tag} = 16'h0000;
      t = (trail >= 8'h80 && trail <= 8'h9E) ? trail + 8'h20 : trail;
      case (lead)
         dfe_pkg::LEAD_C3: begin
            if (trail == 8'h9F) begin
               {base, tag} = "s8";
            end else begin
               case (t)
                  8'hA0: {base, tag} = "a4";
                  8'hA1: {base, tag} = "a2";
                  8'hA2: {base, tag} = "a5";
                  8'hA3: {base, tag} = "a7";
                  8'hA4: {base, tag} = "a6";
                  8'hA7: {base, tag} = {"c", dfe_pkg::NO_TAG};
                  8'hA8: {base, tag} = "e4";
                  8'hA9: {base, tag} = "e2";
                  8'hAA: {base, tag} = "e5";
                  8'hAB: {base, tag} = "e6";
                  8'hAC: {base, tag} = "i4";
                  8'hAD: {base, tag} = "i2";
                  8'hAE: {base, tag} = "i5";
                  8'hAF: {base, tag} = "i6";
                  8'hB1: {base, tag} = "n7";
                  8'hB2: {base, tag} = "o4";
                  8'hB3: {base, tag} = "o2";
                  8'hB4: {base, tag} = "o5";
                  8'hB5: {base, tag} = "o7";
                  8'hB6: {base, tag} = "o6";
                  8'hB9: {base, tag} = "u4";
                  8'hBA: {base, tag} = "u2";
                  8'hBB: {base, tag} = "u5";
                  8'hBC: {base, tag} = "u6";
                  8'hBD: {base, tag} = "y2";
                  8'hBF: {base, tag} = "y6";
                  default: ;
               endcase
            end
         end
         dfe_pkg::LEAD_C4: begin
            case (trail)
               8'h80, 8'h81: {base, tag} = "a1";
               8'h82, 8'h83: {base, tag} = "a3";
               8'h8C, 8'h8D: {base, tag} = "c3";
               8'h8E, 8'h8F: {base, tag} = "d3";
               8'h92, 8'h93: {base, tag} = "e1";
               8'h9A, 8'h9B: {base, tag} = "e3";
               8'h9E, 8'h9F: {base, tag} = "g3";
               8'hAA, 8'hAB: {base, tag} = "i1";
               8'hB1:        {base, tag} = "i8";
               8'hBD, 8'hBE: {base, tag} = "l3";
               default: ;
            endcase
         end
         dfe_pkg::LEAD_C5: begin
            case (trail)
               8'h87, 8'h88: {base, tag} = "n3";
               8'h8C, 8'h8D: {base, tag} = "o1";
               8'h98, 8'h99: {base, tag} = "r3";
               8'h9E, 8'h9F: {base, tag} = {"s", dfe_pkg::NO_TAG};
               8'hA0, 8'hA1: {base, tag} = "s3";
               8'hA4, 8'hA5: {base, tag} = "t3";
               8'hAA, 8'hAB: {base, tag} = "u1";
               8'hAE, 8'hAF: {base, tag} = {"u", dfe_pkg::NO_TAG};
               8'hB8:        {base, tag} = "y6";
               8'hBD, 8'hBE: {base, tag} = "z3";
               default: ;
            endcase
         end
         dfe_pkg::LEAD_C7: begin
            case (trail)
               8'h8D, 8'h8E: {base, tag} = "a3";
               8'h8F, 8'h90: {base, tag} = "i3";
               8'h91, 8'h92: {base, tag} = "o3";
               8'h93, 8'h94: {base, tag} = "u3";
               default: ;
            endcase
         end
         dfe_pkg::LEAD_C8: begin
            case (trail)
               8'h98, 8'h99: {base, tag} = {"s", dfe_pkg::NO_TAG};
               8'h9A, 8'h9B: {base, tag} = {"t", dfe_pkg::NO_TAG};
               default: ;
            endcase
         end
         default: ;
      endcase
      return base != 8'h00;
   endfunction

   // Returns the length of a table entry that starts at scan_buf[at], or 0. The partial flag
   // tells whether the rem bytes seen so far could still grow into an entry.
   function automatic int table_hit(input int at, input int rem, output logic [7:0] base,
                                    output logic [7:0] tag, output bit partial);
      logic [7:0] c0;
      {base, tag} = 16'h0000;
      partial = 1'b0;
      c0 = scan_buf[at];
      if (c0 == dfe_pkg::ASCII_LOWER_L || c0 == dfe_pkg::ASCII_UPPER_L) begin
         if (rem >= 2 && scan_buf[at + 1] != dfe_pkg::LEAD_C2) return 0;
         if (rem >= 3 && scan_buf[at + 2] != dfe_pkg::TRAIL_B7) return 0;
         if (rem < 4) begin
            partial = 1'b1;
            return 0;
         end
         if (scan_buf[at + 3] != dfe_pkg::ASCII_LOWER_L &&
             scan_buf[at + 3] != dfe_pkg::ASCII_UPPER_L) return 0;
         {base, tag} = "l8";
         return 4;
      end
      if (c0 == dfe_pkg::LEAD_E1) begin
         if (rem >= 2 && scan_buf[at + 1] != dfe_pkg::TRAIL_BA) return 0;
         if (rem < 3) begin
            partial = 1'b1;
            return 0;
         end
         if (scan_buf[at + 2] != dfe_pkg::TRAIL_9E) return 0;
         {base, tag} = "s8";
         return 3;
      end
      if (c0 == dfe_pkg::LEAD_C3 || c0 == dfe_pkg::LEAD_C4 || c0 == dfe_pkg::LEAD_C5 ||
          c0 == dfe_pkg::LEAD_C7 || c0 == dfe_pkg::LEAD_C8) begin
         if (rem < 2) begin
            partial = 1'b1;
            return 0;
         end
         return pair_fold(c0, scan_buf[at + 1], base, tag) ? 2 : 0;
      end
      return 0;
   endfunction

   task automatic fold_text_byte(input logic [7:0] b, input logic eot);
      logic [7:0]   outs [$];
      logic [7:0]   base, tag, c;
      fold_out_type item;
      int           n, pos, len;
      bit           partial, waiting;
      n = 0;
      for (int i = 0; i < held_n; i++) begin
         scan_buf[n] = held[i];
         n++;
      end
      if (turk_on && b == dfe_pkg::TRAIL_B0 && n == 1 && scan_buf[0] == dfe_pkg::LEAD_C4) begin
         scan_buf[0] = dfe_pkg::ASCII_LOWER_I;
      end else if (turk_on && b == dfe_pkg::ASCII_UPPER_I) begin
         scan_buf[n] = dfe_pkg::LEAD_C4;
         scan_buf[n + 1] = dfe_pkg::TRAIL_B1;
         n += 2;
      end else begin
         scan_buf[n] = b;
         n++;
      end
      pos = 0;
      waiting = 1'b0;
      while (pos < n && !waiting) begin
         len = table_hit(pos, n - pos, base, tag, partial);
         if (len > 0) begin
            outs.push_back(base);
            if (tag != dfe_pkg::NO_TAG) outs.push_back(tag);
            pos += len;
         end else if (partial && !eot) begin
            waiting = 1'b1;
         end else begin
            c = scan_buf[pos];
            if (c >= "A" && c <= "Z") begin
               outs.push_back(c + 8'd32);
            end else if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
                         c == " " || c == "#" || c == "/") begin
               outs.push_back(c);
            end
            pos++;
         end
      end
      held_n = 0;
      for (int i = pos; i < n && held_n < 3; i++) begin
         held[held_n] = scan_buf[i];
         held_n++;
      end
      if (outs.size() == 0) begin
         if (eot) begin
            item.out_byte = 8'h00;
            item.has_byte = 1'b0;
            item.last = 1'b1;
            fold_q.push_back(item);
         end
      end else begin
         foreach (outs[i]) begin
            item.out_byte = outs[i];
            item.has_byte = 1'b1;
            item.last = (i == outs.size() - 1);
            fold_q.push_back(item);
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_result();
      fold_out_type want;
      rsp_seen++;
      if (!rsp_tuser) marker_seen++;
      if (fold_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected beat, got byte=%h has_byte=%b last=%b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = fold_q.pop_front();
         if (rsp_tdata !== want.out_byte || rsp_tuser !== want.has_byte ||
             rsp_tlast !== want.last) begin
            errors++;
            $display("%0t: expected byte=%h has_byte=%b last=%b, got byte=%h has_byte=%b last=%b",
                     $time, want.out_byte, want.has_byte, want.last,
                     rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tlast <= 1'b0;
         send_gap = 0;
         held_n = 0;
         turk_on = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            fold_text_byte(req_tdata, req_tlast);
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (text_q.size() != 0) begin
               next_in = text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_in.text;
               req_tlast <= next_in.eot;
               send_gap = send_calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (!squeezed && rsp_seen >= SQUEEZE_AFTER && text_q.size() > 20) begin
            squeezed = 1'b1;
            recv_hold = SQUEEZE_CYCLES;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else if (recv_calm || $urandom_range(0, 99) < 55) begin
            rsp_tready <= 1'b1;
         end else begin
            recv_hold = pick_gap();
            rsp_tready <= 1'b0;
         end
         if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_text(input logic [7:0] b, input logic eot = 1'b0);
      text_in_type beat;
      beat.text = b;
      beat.eot = eot;
      text_q.push_back(beat);
      pushed++;
   endtask

   task automatic drain();
      while (beats_in != pushed || fold_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_mode(input logic turkish);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= turkish;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      turk_on = turkish;
      @(negedge clock);
   endtask

   // Mostly well-formed letters and table sequences, with some truncated or corrupted
   // sequences and raw noise mixed in.
   task automatic add_random_word();
      logic [7:0] word [$];
      logic [7:0] lead, trail, base, tag, c;
      int         pick, keep;
      bit         eot;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         case ($urandom_range(0, 3))
            0: c = 8'("A" + $urandom_range(0, 25));
            1: c = 8'("a" + $urandom_range(0, 25));
            2: c = 8'("0" + $urandom_range(0, 9));
            default: begin
               case ($urandom_range(0, 2))
                  0: c = " ";
                  1: c = "#";
                  default: c = "/";
               endcase
            end
         endcase
         word.push_back(c);
      end else if (pick < 65) begin
         do begin
            case ($urandom_range(0, 4))
               0: lead = dfe_pkg::LEAD_C3;
               1: lead = dfe_pkg::LEAD_C4;
               2: lead = dfe_pkg::LEAD_C5;
               3: lead = dfe_pkg::LEAD_C7;
               default: lead = dfe_pkg::LEAD_C8;
            endcase
            trail = 8'($urandom_range(8'h80, 8'hBF));
         end while (!pair_fold(lead, trail, base, tag));
         word.push_back(lead);
         word.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : trail);
      end else if (pick < 75) begin
         word.push_back($urandom_range(0, 1) ? dfe_pkg::ASCII_LOWER_L : dfe_pkg::ASCII_UPPER_L);
         word.push_back(dfe_pkg::LEAD_C2);
         word.push_back(dfe_pkg::TRAIL_B7);
         word.push_back($urandom_range(0, 1) ? dfe_pkg::ASCII_LOWER_L : dfe_pkg::ASCII_UPPER_L);
      end else if (pick < 82) begin
         word.push_back(dfe_pkg::LEAD_E1);
         word.push_back(dfe_pkg::TRAIL_BA);
         word.push_back(dfe_pkg::TRAIL_9E);
      end else if (pick < 90) begin
         case ($urandom_range(0, 2))
            0: word.push_back(dfe_pkg::ASCII_UPPER_I);
            1: begin
               word.push_back(dfe_pkg::LEAD_C4);
               word.push_back(dfe_pkg::TRAIL_B0);
            end
            default: begin
               word.push_back(dfe_pkg::LEAD_C4);
               word.push_back(dfe_pkg::TRAIL_B1);
            end
         endcase
      end else begin
         word.push_back(8'($urandom));
      end
      if (pick >= 65 && pick < 82 && $urandom_range(0, 3) == 0) begin
         keep = $urandom_range(1, word.size() - 1);
         while (word.size() > keep) void'(word.pop_back());
         if ($urandom_range(0, 1)) word.push_back(8'($urandom));
      end
      eot = ($urandom_range(0, 9) == 0);
      foreach (word[i]) add_text(word[i], eot && i == word.size() - 1);
      if (pick < 90) useful += word.size();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      drain();

      set_mode(1'b0);
      add_text("A");
      add_text("z");
      add_text(8'h00);
      add_text(8'hFF);
      add_text(dfe_pkg::LEAD_C3);
      add_text(8'hA9);
      add_text(dfe_pkg::ASCII_LOWER_L);
      add_text(dfe_pkg::LEAD_C2);
      add_text(dfe_pkg::TRAIL_B7);
      add_text(dfe_pkg::ASCII_UPPER_L);
      add_text(dfe_pkg::LEAD_E1);
      add_text(dfe_pkg::TRAIL_BA);
      add_text(dfe_pkg::TRAIL_9E);
      add_text(dfe_pkg::ASCII_UPPER_I);
      add_text(dfe_pkg::LEAD_C4);
      add_text(dfe_pkg::TRAIL_B0);
      add_text(dfe_pkg::ASCII_LOWER_L);
      add_text(dfe_pkg::LEAD_C2, 1'b1);
      add_text(8'h7F, 1'b1);
      add_text(dfe_pkg::LEAD_C4);
      drain();

      // A lead byte left pending across the mode change is resolved under the new mode.
      set_mode(1'b1);
      add_text(dfe_pkg::TRAIL_B0);
      add_text(dfe_pkg::ASCII_UPPER_I);
      add_text(dfe_pkg::LEAD_C4);
      add_text(dfe_pkg::TRAIL_B0);
      add_text("/", 1'b1);
      add_text(dfe_pkg::LEAD_C4);
      drain();
      set_mode(1'b0);
      add_text(dfe_pkg::TRAIL_B0, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         set_mode(ph % 2 == 0);
         while (useful < (ph + 1) * PHASE_BYTES) add_random_word();
      end
      drain();
      repeat (20) @(negedge clock);

      $display("Folded %0d text beats into %0d result beats (%0d bare end markers),",
               beats_in, rsp_seen, marker_seen);
      $display("in both I-casing modes, with a %0d-cycle receiver stall under load.",
               SQUEEZE_CYCLES);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
